[rtl/boalu_pkg.sv]
package boalu_pkg;

  localparam int unsigned OpWidth   = 5;
  localparam int unsigned DataWidth = 8;

  typedef logic [OpWidth-1:0]   op_t;
  typedef logic [DataWidth-1:0] byte_t;

  localparam op_t OP_ADD    = 5'd0;
  localparam op_t OP_AND    = 5'd1;
  localparam op_t OP_XOR    = 5'd2;
  localparam op_t OP_SUB    = 5'd3;
  localparam op_t OP_CLRW   = 5'd4;
  localparam op_t OP_MOVWF  = 5'd5;
  localparam op_t OP_CLRF   = 5'd6;
  localparam op_t OP_COMF   = 5'd7;
  localparam op_t OP_DECF   = 5'd8;
  localparam op_t OP_INCF   = 5'd9;
  localparam op_t OP_MOVF   = 5'd10;
  localparam op_t OP_IOR    = 5'd11;
  localparam op_t OP_DECFSZ = 5'd12;
  localparam op_t OP_INCFSZ = 5'd13;
  localparam op_t OP_RLF    = 5'd14;
  localparam op_t OP_RRF    = 5'd15;
  localparam op_t OP_NOP    = 5'd16;
  localparam op_t OP_SWAPF  = 5'd17;

  // Result of one instruction as it leaves the ALU.
  typedef struct packed {
    logic  file_write;
    byte_t file_data;
    byte_t w_value;
    logic  carry;
    logic  digit_carry;
    logic  zero;
    logic  skip;
  } alu_result_t;

endpackage

[rtl/byte_oriented_alu_with_flags.sv]
// An accepted instruction passes through the input register and then the result register.
// Throughput: one instruction per cycle while out_stall is low; the input register feeds
// the ALU and result register, and W and the flags are updated as the result is captured.
// Reset: rst_n is synchronous and active low; it clears W, C, DC, Z and both valid bits.
module byte_oriented_alu_with_flags
  import boalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] in_operation,
  input  logic       in_dest_file,
  input  logic [7:0] in_file_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_file_write,
  output logic [7:0] out_file_data,
  output logic [7:0] out_w_value,
  output logic       out_carry_out,
  output logic       out_digit_carry_out,
  output logic       out_zero_out,
  output logic       out_skip_next
);

  // Input register stage. The payload needs no reset; only the valid bit does.
  logic  in_valid_r;
  op_t   op_r;
  logic  dest_r;
  byte_t fval_r;

  // Output register stage.
  logic        out_valid_r;
  alu_result_t res_r;
  alu_result_t res_nxt;

  // Architectural state: working register and the three status flags.
  byte_t w_r;
  logic  c_r;
  logic  dc_r;
  logic  z_r;

  // The output register can take a new transaction when it is empty or being drained.
  logic out_load;
  logic in_load;

  assign out_load = in_valid_r && (!out_valid_r || !out_stall);
  // The input register is free when empty or when its contents move on this cycle.
  assign in_stall = in_valid_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_load) begin
      op_r   <= in_operation;
      dest_r <= in_dest_file;
      fval_r <= in_file_value;
    end
  end

  // ALU: a 9-bit add, a 5-bit nibble add, an 8-bit subtract with byte and nibble compares, and muxing.
  always_comb begin
    logic [8:0] sum;
    logic [4:0] nib_sum;
    byte_t      res;
    logic       has_result;
    logic       set_z;

    sum        = {1'b0, fval_r} + {1'b0, w_r};
    nib_sum    = {1'b0, fval_r[3:0]} + {1'b0, w_r[3:0]};
    res        = '0;
    has_result = 1'b1;
    set_z      = 1'b0;

    res_nxt.file_write  = 1'b0;
    res_nxt.file_data   = '0;
    res_nxt.w_value     = w_r;
    res_nxt.carry       = c_r;
    res_nxt.digit_carry = dc_r;
    res_nxt.zero        = z_r;
    res_nxt.skip        = 1'b0;

    case (op_r)
      OP_ADD: begin
        res                 = sum[7:0];
        res_nxt.carry       = sum[8];
        res_nxt.digit_carry = nib_sum[4];
        set_z               = 1'b1;
      end
      OP_SUB: begin
        res                 = fval_r - w_r;
        res_nxt.carry       = (fval_r >= w_r);
        res_nxt.digit_carry = (fval_r[3:0] >= w_r[3:0]);
        set_z               = 1'b1;
      end
      OP_AND: begin
        res   = fval_r & w_r;
        set_z = 1'b1;
      end
      OP_IOR: begin
        res   = fval_r | w_r;
        set_z = 1'b1;
      end
      OP_XOR: begin
        res   = fval_r ^ w_r;
        set_z = 1'b1;
      end
      OP_COMF: begin
        res   = ~fval_r;
        set_z = 1'b1;
      end
      OP_DECF: begin
        res   = fval_r - 8'd1;
        set_z = 1'b1;
      end
      OP_INCF: begin
        res   = fval_r + 8'd1;
        set_z = 1'b1;
      end
      OP_MOVF: begin
        res   = fval_r;
        set_z = 1'b1;
      end
      OP_DECFSZ: begin
        res          = fval_r - 8'd1;
        res_nxt.skip = (res == '0);
      end
      OP_INCFSZ: begin
        res          = fval_r + 8'd1;
        res_nxt.skip = (res == '0);
      end
      OP_RLF: begin
        res           = {fval_r[6:0], c_r};
        res_nxt.carry = fval_r[7];
      end
      OP_RRF: begin
        res           = {c_r, fval_r[7:1]};
        res_nxt.carry = fval_r[0];
      end
      OP_SWAPF: begin
        res = {fval_r[3:0], fval_r[7:4]};
      end
      OP_CLRW: begin
        has_result      = 1'b0;
        res_nxt.w_value = '0;
        res_nxt.zero    = 1'b1;
      end
      OP_MOVWF: begin
        has_result         = 1'b0;
        res_nxt.file_write = 1'b1;
        res_nxt.file_data  = w_r;
      end
      OP_CLRF: begin
        has_result         = 1'b0;
        res_nxt.file_write = 1'b1;
        res_nxt.zero       = 1'b1;
      end
      default: begin
        // NOP and every unused opcode leave all state alone.
        has_result = 1'b0;
      end
    endcase

    if (has_result) begin
      if (set_z) begin
        res_nxt.zero = (res == '0);
      end
      if (dest_r) begin
        res_nxt.file_write = 1'b1;
        res_nxt.file_data  = res;
      end else begin
        res_nxt.w_value = res;
      end
    end
  end

  // State and result are captured together, so the next instruction in the
  // input register always sees the W and flags left by the one before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      w_r         <= '0;
      c_r         <= 1'b0;
      dc_r        <= 1'b0;
      z_r         <= 1'b0;
    end else begin
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= in_valid_r;
      end
      if (out_load) begin
        w_r  <= res_nxt.w_value;
        c_r  <= res_nxt.carry;
        dc_r <= res_nxt.digit_carry;
        z_r  <= res_nxt.zero;
      end
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_file_write      = res_r.file_write;
  assign out_file_data       = res_r.file_data;
  assign out_w_value         = res_r.w_value;
  assign out_carry_out       = res_r.carry;
  assign out_digit_carry_out = res_r.digit_carry;
  assign out_zero_out        = res_r.zero;
  assign out_skip_next       = res_r.skip;

`ifndef ASSERT_OFF
  // A skip is only raised when the decremented or incremented byte is zero.
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.skip |->
      (res_r.file_write ? (res_r.file_data == '0) : (res_r.w_value == '0)))
    else $error("skip raised with a nonzero result");

  // Without a file write the file data is held at zero.
  a_no_write_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.file_write |-> res_r.file_data == '0)
    else $error("file data nonzero without a file write");

  // The presented result always matches the architectural state.
  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (w_r == res_r.w_value) && (c_r == res_r.carry) &&
                    (dc_r == res_r.digit_carry) && (z_r == res_r.zero))
    else $error("output result and state registers disagree");

  // The input side only stalls while it holds a transaction.
  a_stall_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked transaction");
`endif

endmodule
